FILE: design/assert_macros.svh
// Assertion macros shared by the enable router RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that prop holds at every clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Check that cond implies prop in the same cycle
`define ASSERT_IMPL(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed");

// Check that cond implies prop in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed");

`endif

FILE: design/irqaer_pkg.sv
// Types and constants of the interrupt enable router
`default_nettype none

package irqaer_pkg;

  typedef enum logic [1:0] {
    REQ_ENABLE       = 2'd0,
    REQ_DISABLE      = 2'd1,
    REQ_SET_AFFINITY = 2'd2,
    REQ_RESERVED     = 2'd3
  } req_type_e;

  localparam logic [1:0] STATUS_OK         = 2'd0;
  localparam logic [1:0] STATUS_BAD_SOURCE = 2'd1;
  localparam logic [1:0] STATUS_EMPTY_MASK = 2'd2;

  localparam int unsigned SrcIdW  = 10;
  localparam int unsigned HartIdW = 3;
  localparam int unsigned WordIdW = 5;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned CountW  = 6;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_CHECK,
    S_SRC,
    S_BANK_RD,
    S_BANK_WR
  } state_e;

  typedef struct packed {
    logic clr_step;
    logic load;
    logic src_rd;
    logic src_upd;
    logic bank_rd;
    logic bank_wr;
    logic emit_err;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic req_ignored;
    logic src_bad;
    logic mask_empty;
    logic hart_last;
  } ctrl_status_t;

endpackage

`default_nettype wire

FILE: design/irqaer_ctrl.sv
// Controller state machine of the interrupt enable router
`default_nettype none

module irqaer_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start,
  output logic                    busy,
  input  irqaer_pkg::ctrl_status_t status_i,
  output irqaer_pkg::ctrl_cmd_t    cmd_o
);

  irqaer_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= irqaer_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      irqaer_pkg::S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_done) begin
          state_d = irqaer_pkg::S_IDLE;
        end
      end
      irqaer_pkg::S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = irqaer_pkg::S_CHECK;
        end
      end
      irqaer_pkg::S_CHECK: begin
        if (status_i.req_ignored) begin
          state_d = irqaer_pkg::S_IDLE;
        end else if (status_i.src_bad || status_i.mask_empty) begin
          cmd_o.emit_err = 1'b1;
          state_d        = irqaer_pkg::S_IDLE;
        end else begin
          cmd_o.src_rd = 1'b1;
          state_d      = irqaer_pkg::S_SRC;
        end
      end
      irqaer_pkg::S_SRC: begin
        cmd_o.src_upd = 1'b1;
        state_d       = irqaer_pkg::S_BANK_RD;
      end
      irqaer_pkg::S_BANK_RD: begin
        cmd_o.bank_rd = 1'b1;
        state_d       = irqaer_pkg::S_BANK_WR;
      end
      irqaer_pkg::S_BANK_WR: begin
        cmd_o.bank_wr = 1'b1;
        state_d       = status_i.hart_last ? irqaer_pkg::S_IDLE : irqaer_pkg::S_BANK_RD;
      end
      default: begin
        state_d = irqaer_pkg::S_IDLE;
      end
    endcase
  end

  assign busy = (state_q != irqaer_pkg::S_IDLE);

endmodule

`default_nettype wire

FILE: design/irqaer_datapath.sv
// Datapath of the interrupt enable router: tables, enable bank, result register
`default_nettype none

module irqaer_datapath #(
  parameter int unsigned NUM_SOURCES = 64,
  parameter int unsigned MAX_HARTS   = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  irqaer_pkg::ctrl_cmd_t    cmd_i,
  output irqaer_pkg::ctrl_status_t status_o,
  input  logic                    cfg_valid_i,
  input  logic [irqaer_pkg::CfgW-1:0] cfg_active_harts_i,
  input  logic [1:0]              req_type_i,
  input  logic [irqaer_pkg::SrcIdW-1:0] source_id_i,
  input  logic [MAX_HARTS-1:0]    hart_mask_i,
  output logic                    result_valid_o,
  output logic [1:0]              res_status_o,
  output logic                    write_valid_o,
  output logic [irqaer_pkg::HartIdW-1:0] hart_index_o,
  output logic [irqaer_pkg::WordIdW-1:0] word_index_o,
  output logic [31:0]             enable_word_o,
  output logic                    priority_write_o,
  output logic                    priority_value_o,
  output logic                    last_o
);

  localparam int unsigned Words     = (NUM_SOURCES + 31) / 32;
  localparam int unsigned BankDepth = MAX_HARTS * Words;
  localparam int unsigned BankAw    = (BankDepth > 1) ? $clog2(BankDepth) : 1;
  localparam int unsigned SrcAw     = $clog2(NUM_SOURCES);
  localparam int unsigned HartW     = (MAX_HARTS > 1) ? $clog2(MAX_HARTS) : 1;
  localparam int unsigned ClrLen    = (NUM_SOURCES > BankDepth) ? NUM_SOURCES : BankDepth;
  localparam int unsigned ClrW      = $clog2(ClrLen);
  localparam int unsigned CntW      = irqaer_pkg::CountW;

  // Source table entry: {enabled, affinity}
  logic [MAX_HARTS:0] src_mem [NUM_SOURCES];
  logic [31:0]        bank_mem [BankDepth];

  logic [irqaer_pkg::CfgW-1:0]   active_q;
  logic [ClrW-1:0]               clr_q;
  logic [1:0]                    type_q;
  logic [irqaer_pkg::SrcIdW-1:0] src_q;
  logic [MAX_HARTS-1:0]          req_q;
  logic [MAX_HARTS:0]            src_rdata_q;
  logic [31:0]                   bank_rdata_q;
  logic [MAX_HARTS-1:0]          mask_q;
  logic                          en_q;
  logic [HartW-1:0]              hart_q;

  logic [CntW-1:0]      hart_cnt;
  logic [CntW-1:0]      last_idx;
  logic [MAX_HARTS-1:0] valid_mask;
  logic [MAX_HARTS-1:0] new_mask;
  logic [MAX_HARTS-1:0] masked;
  logic                 new_en;
  logic [BankAw-1:0]    bank_addr;
  logic [31:0]          bit_sel;
  logic [31:0]          new_word;
  logic                 hart_on;
  logic                 clr_in_src;
  logic                 clr_in_bank;
  logic                 src_we;
  logic [SrcAw-1:0]     src_waddr;
  logic [MAX_HARTS:0]   src_wdata;
  logic                 bank_we;
  logic [BankAw-1:0]    bank_waddr;
  logic [31:0]          bank_wdata;

  // Hart count clamped to 1..MAX_HARTS
  always_comb begin
    hart_cnt = (active_q == '0) ? CntW'(1) : CntW'(active_q);
    if (hart_cnt > CntW'(MAX_HARTS)) begin
      hart_cnt = CntW'(MAX_HARTS);
    end
    last_idx = hart_cnt - CntW'(1);
    for (int i = 0; i < MAX_HARTS; i++) begin
      valid_mask[i] = (CntW'(i) < hart_cnt);
    end
  end

  assign status_o.clr_done    = (clr_q == ClrW'(ClrLen - 1));
  assign status_o.req_ignored = (type_q == irqaer_pkg::REQ_RESERVED);
  assign status_o.src_bad     = (src_q == '0) ||
                                ({1'b0, src_q} >= (irqaer_pkg::SrcIdW + 1)'(NUM_SOURCES));
  assign status_o.mask_empty  = (type_q == irqaer_pkg::REQ_SET_AFFINITY) &&
                                ((req_q & valid_mask) == '0);
  assign status_o.hart_last   = (CntW'(hart_q) == last_idx);

  always_comb begin
    if (type_q == irqaer_pkg::REQ_SET_AFFINITY) begin
      masked = req_q & valid_mask;
      new_en = src_rdata_q[MAX_HARTS];
    end else begin
      masked = src_rdata_q[MAX_HARTS-1:0] & valid_mask;
      new_en = (type_q == irqaer_pkg::REQ_ENABLE);
    end
    new_mask = (masked == '0) ? MAX_HARTS'(1) : masked;
  end

  assign bank_addr = BankAw'(BankAw'(hart_q) * BankAw'(Words) + BankAw'(src_q[9:5]));
  assign bit_sel   = 32'(1) << src_q[4:0];
  assign hart_on   = en_q && mask_q[hart_q];
  assign new_word  = hart_on ? (bank_rdata_q | bit_sel) : (bank_rdata_q & ~bit_sel);

  assign clr_in_src  = ({1'b0, clr_q} < (ClrW + 1)'(NUM_SOURCES));
  assign clr_in_bank = ({1'b0, clr_q} < (ClrW + 1)'(BankDepth));

  always_comb begin
    src_we     = (cmd_i.clr_step && clr_in_src) || cmd_i.src_upd;
    src_waddr  = cmd_i.clr_step ? clr_q[SrcAw-1:0] : src_q[SrcAw-1:0];
    src_wdata  = cmd_i.clr_step ? {1'b0, MAX_HARTS'(1)} : {new_en, new_mask};
    bank_we    = (cmd_i.clr_step && clr_in_bank) || cmd_i.bank_wr;
    bank_waddr = cmd_i.clr_step ? clr_q[BankAw-1:0] : bank_addr;
    bank_wdata = cmd_i.clr_step ? '0 : new_word;
  end

  always_ff @(posedge clk_i) begin
    if (src_we) begin
      src_mem[src_waddr] <= src_wdata;
    end
    if (cmd_i.src_rd) begin
      src_rdata_q <= src_mem[src_q[SrcAw-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (bank_we) begin
      bank_mem[bank_waddr] <= bank_wdata;
    end
    if (cmd_i.bank_rd) begin
      bank_rdata_q <= bank_mem[bank_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q       <= irqaer_pkg::CfgW'(1);
      clr_q          <= '0;
      result_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        active_q <= cfg_active_harts_i;
      end
      if (cmd_i.clr_step && !status_o.clr_done) begin
        clr_q <= clr_q + ClrW'(1);
      end
      result_valid_o <= cmd_i.emit_err || cmd_i.bank_wr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      type_q <= req_type_i;
      src_q  <= source_id_i;
      req_q  <= hart_mask_i;
    end
    if (cmd_i.src_upd) begin
      mask_q <= new_mask;
      en_q   <= new_en;
      hart_q <= '0;
    end else if (cmd_i.bank_wr) begin
      hart_q <= hart_q + HartW'(1);
    end
    if (cmd_i.emit_err) begin
      res_status_o     <= status_o.src_bad ? irqaer_pkg::STATUS_BAD_SOURCE
                                           : irqaer_pkg::STATUS_EMPTY_MASK;
      write_valid_o    <= 1'b0;
      hart_index_o     <= '0;
      word_index_o     <= '0;
      enable_word_o    <= '0;
      priority_write_o <= 1'b0;
      priority_value_o <= 1'b0;
      last_o           <= 1'b1;
    end else if (cmd_i.bank_wr) begin
      res_status_o     <= irqaer_pkg::STATUS_OK;
      write_valid_o    <= 1'b1;
      hart_index_o     <= irqaer_pkg::HartIdW'(hart_q);
      word_index_o     <= src_q[9:5];
      enable_word_o    <= new_word;
      priority_write_o <= status_o.hart_last && (type_q != irqaer_pkg::REQ_SET_AFFINITY);
      priority_value_o <= status_o.hart_last && (type_q == irqaer_pkg::REQ_ENABLE);
      last_o           <= status_o.hart_last;
    end
  end

endmodule

`default_nettype wire

FILE: design/irq_affinity_enable_router.sv
// Top level of the interrupt enable router: controller, datapath and checks
// After reset the block runs a clearing pass over its source table and enable
// bank, with busy high; configuration writes are taken throughout. A request is
// taken when start is high and busy low. A valid request goes through a check
// state (checks and source table read), a source table update state, then a
// read state and a write state of the enable bank for each active hart, their
// number being active_harts clamped to 1..MAX_HARTS; busy stays high until the
// last hart's write, and no new request is taken before then. A rejected
// request keeps busy high for one cycle and its single result is on the ports
// in the cycle after; a reserved request type gives none. Each result is shown
// for one cycle under result_valid_o, the cycle after it is formed, and cannot
// be held off by the receiver.
`default_nettype none
`include "assert_macros.svh"

module irq_affinity_enable_router #(
  parameter int unsigned NUM_SOURCES = 64,
  parameter int unsigned MAX_HARTS   = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [9:0]  source_id_i,
  input  logic [31:0] hart_mask_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_active_harts_i,
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic        write_valid_o,
  output logic [2:0]  hart_index_o,
  output logic [4:0]  word_index_o,
  output logic [31:0] enable_word_o,
  output logic        priority_write_o,
  output logic        priority_value_o,
  output logic        last_o
);

  irqaer_pkg::ctrl_cmd_t    cmd;
  irqaer_pkg::ctrl_status_t ctrl_status;

  assign cfg_ready_o = 1'b1;

  irqaer_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (ctrl_status),
    .cmd_o    (cmd)
  );

  irqaer_datapath #(
    .NUM_SOURCES (NUM_SOURCES),
    .MAX_HARTS   (MAX_HARTS)
  ) u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (ctrl_status),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_active_harts_i (cfg_active_harts_i),
    .req_type_i         (req_type_i),
    .source_id_i        (source_id_i),
    .hart_mask_i        (hart_mask_i[MAX_HARTS-1:0]),
    .result_valid_o     (result_valid_o),
    .res_status_o       (status_o),
    .write_valid_o      (write_valid_o),
    .hart_index_o       (hart_index_o),
    .word_index_o       (word_index_o),
    .enable_word_o      (enable_word_o),
    .priority_write_o   (priority_write_o),
    .priority_value_o   (priority_value_o),
    .last_o             (last_o)
  );

  `ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)
  `ASSERT_IMPL(a_result_in_req, clk_i, rst_ni, result_valid_o, $past(busy))
  `ASSERT_IMPL(a_err_is_last, clk_i, rst_ni, result_valid_o && !write_valid_o, last_o && (status_o != irqaer_pkg::STATUS_OK))
  `ASSERT_IMPL(a_prio_on_last, clk_i, rst_ni, result_valid_o && priority_write_o, last_o && write_valid_o)

endmodule

`default_nettype wire
